[hw/rtl/gww_pkg.sv]
// gww_pkg: shared constants and codes for the greedy word wrap block
// no dependencies; used by greedy_word_wrap_unit and gww_checker
`default_nettype none

package gww_pkg;

  localparam int GWW_GLYPH_COUNT = 256;

  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [7:0]  NULL_CODE    = 8'h00;
  localparam logic [15:0] MAX16        = 16'hFFFF;
  localparam logic [15:0] WRAP_RESET   = 16'd320;

  localparam logic CMD_TEXT  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;

  localparam int OUT_HAS_WORD_BIT = 0;
  localparam int OUT_NEW_LINE_BIT = 1;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd1;
    return s[16] ? MAX16 : s[15:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/greedy_word_wrap_unit.sv]
// greedy_word_wrap_unit: greedy word placement over a text byte stream
// glyph width table in a synchronous memory; uses gww_pkg
//
// usage
//   in_*  : one beat per text byte or per glyph table write (in_tuser = cmd)
//           in_tlast marks the final byte of a text
//   out_* : one beat per placed word or end of text; one beat may be both
//   cfg_* : wrap width write; the user writes it only while idle, not enforced
// path: beat and table read registered, update stage loads the output register
// throughput: one input beat per cycle unless stalled; the table is read once per beat
//   into a registered read port, then one add-and-compare stage updates the
//   line state, so a new beat is taken every cycle the output does not stall
// reset: line state cleared, wrap width 320, every table entry reads zero
//   through per-entry valid bits, no clearing pass
// stall: the output register holds its beat while out_tready is low; once
//   it is full and not drained, the update stage and in_tready hold too
`default_nettype none

module greedy_word_wrap_unit
  import gww_pkg::*;
#(
  parameter int GLYPH_COUNT = GWW_GLYPH_COUNT
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output      logic                    in_tready,
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,   // code[7:0], glyph_px[15:8]
  input  wire logic                    in_tuser,   // cmd
  input  wire logic                    in_tlast,   // end_of_text
  output      logic                    out_tvalid,
  input  wire logic                    out_tready,
  output      logic [OUT_TDATA_W-1:0]  out_tdata,  // line_idx, word_width,
                                                   // line_px, line_count
  output      logic [OUT_TUSER_W-1:0]  out_tuser,  // has_word[0], new_line[1]
  output      logic                    out_tlast,  // last
  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire logic [15:0]             cfg_data    // wrap_width
);

  localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

  // input side
  logic [7:0]    in_code;
  logic [7:0]    in_gw;
  logic          in_acc;
  logic          in_range;
  logic [AW-1:0] in_addr;
  logic          tbl_wr;

  // glyph table
  logic [7:0]             tbl_mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] tbl_vld_r;
  logic [7:0]             rd_data_r;
  logic                   rd_ok_r;
  logic [7:0]             space_w_r;

  // update stage
  logic       s1_vld_r;
  logic       s1_cmd_r;
  logic [7:0] s1_code_r;
  logic       s1_eot_r;
  logic       s1_adv;

  // line state
  logic [15:0] wrap_r;
  logic [15:0] line_acc_r, line_acc_nxt;
  logic [15:0] word_acc_r, word_acc_nxt;
  logic [15:0] line_num_r, line_num_nxt;
  logic        in_word_r, in_word_nxt;
  logic        lhw_r, lhw_nxt;

  // output register
  logic                   out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;
  logic                   out_last_r;

  // update logic
  logic        is_text, is_space, add_glyph;
  logic [7:0]  glyph;
  logic [16:0] word_sum;
  logic [15:0] word_eff;
  logic        in_word_eff;
  logic [7:0]  space_add;
  logic [17:0] cand;
  logic        nl;
  logic        place, emit;
  logic [15:0] res_idx, res_ww, res_lw;

  assign in_code   = in_tdata[7:0];
  assign in_gw     = in_tdata[15:8];
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = {1'b0, in_code} < GLYPH_LIMIT;
  assign in_addr   = in_code[AW-1:0];
  assign tbl_wr    = in_acc && (in_tuser == CMD_WRITE) && in_range;

  assign cfg_ready = 1'b1;

  // table memory: write and registered read on the accepted beat
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      tbl_mem[in_addr] <= in_gw;
    end
    if (in_acc) begin
      rd_data_r <= tbl_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      rd_ok_r   <= 1'b0;
      space_w_r <= '0;
    end else begin
      if (tbl_wr) begin
        tbl_vld_r[in_addr] <= 1'b1;
      end
      if (in_acc) begin
        rd_ok_r <= in_range && tbl_vld_r[in_addr];
      end
      if (tbl_wr && (in_code == SPACE_CODE)) begin
        space_w_r <= in_gw;
      end
    end
  end

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;

  always_comb begin
    is_text     = (s1_cmd_r == CMD_TEXT);
    is_space    = (s1_code_r == SPACE_CODE);
    add_glyph   = !is_space && (s1_code_r != NULL_CODE);
    glyph       = rd_ok_r ? rd_data_r : 8'd0;
    word_sum    = {1'b0, word_acc_r} + {9'd0, glyph};
    word_eff    = add_glyph ? (word_sum[16] ? MAX16 : word_sum[15:0]) : word_acc_r;
    in_word_eff = in_word_r || add_glyph;
    space_add   = lhw_r ? space_w_r : 8'd0;
    cand        = {2'b0, line_acc_r} + {2'b0, word_eff} + {10'd0, space_add};
    nl          = cand > {2'b0, wrap_r};
    place       = is_text && ((is_space && in_word_r && !s1_eot_r)
                              || (s1_eot_r && in_word_eff));
    emit        = place || (is_text && s1_eot_r);

    line_acc_nxt = line_acc_r;
    word_acc_nxt = word_acc_r;
    line_num_nxt = line_num_r;
    in_word_nxt  = in_word_r;
    lhw_nxt      = lhw_r;
    res_idx      = line_num_r;
    res_ww       = 16'd0;
    res_lw       = line_acc_r;

    if (place) begin
      res_idx = nl ? sat_inc16(line_num_r) : line_num_r;
      res_lw  = nl ? word_eff : (|cand[17:16] ? MAX16 : cand[15:0]);
      res_ww  = word_eff;
    end

    if (is_text) begin
      priority if (s1_eot_r) begin
        line_acc_nxt = '0;
        word_acc_nxt = '0;
        line_num_nxt = '0;
        in_word_nxt  = 1'b0;
        lhw_nxt      = 1'b0;
      end else if (place) begin
        line_acc_nxt = res_lw;
        word_acc_nxt = '0;
        line_num_nxt = res_idx;
        in_word_nxt  = 1'b0;
        lhw_nxt      = 1'b1;
      end else begin
        word_acc_nxt = word_eff;
        in_word_nxt  = in_word_eff;
      end
    end

    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (s1_adv && emit) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      wrap_r     <= WRAP_RESET;
      line_acc_r <= '0;
      word_acc_r <= '0;
      line_num_r <= '0;
      in_word_r  <= 1'b0;
      lhw_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (cfg_valid && cfg_ready) begin
        wrap_r <= cfg_data;
      end
      if (s1_adv) begin
        line_acc_r <= line_acc_nxt;
        word_acc_r <= word_acc_nxt;
        line_num_r <= line_num_nxt;
        in_word_r  <= in_word_nxt;
        lhw_r      <= lhw_nxt;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_tuser;
      s1_code_r <= in_code;
      s1_eot_r  <= in_tlast;
    end
    if (s1_adv && emit) begin
      out_data_r <= {sat_inc16(res_idx), res_lw, res_ww, res_idx};
      out_user_r <= {place && nl, place};
      out_last_r <= s1_eot_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[hw/rtl/gww_checker.sv]
// gww_checker: port-level checks on the result channel of the word wrap block
// uses gww_pkg; bound to greedy_word_wrap_unit at the end of this file
`default_nettype none

module gww_checker
  import gww_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser,
  input wire logic                   out_tlast
);

  // held beat stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  a_nl_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_NEW_LINE_BIT] |-> out_tuser[OUT_HAS_WORD_BIT])
    else $error("new line without a placed word");

  a_empty_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[OUT_HAS_WORD_BIT] |-> out_tlast
      && (out_tdata[31:16] == 16'd0))
    else $error("wordless beat not a closing beat");

  a_line_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:48] == sat_inc16(out_tdata[15:0]))
    else $error("line count does not follow line index");

endmodule

bind greedy_word_wrap_unit gww_checker u_gww_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[sim/greedy_word_wrap_unit_tb.sv]
// greedy_word_wrap_unit_tb: self-checking bench for the greedy word wrap block
// drives text beats, glyph table writes and wrap width writes; a scoreboard class
// predicts every result beat; depends on gww_pkg and greedy_word_wrap_unit
module greedy_word_wrap_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gww_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    logic        has_word;
    logic        new_line;
    logic [15:0] line_idx;
    logic [15:0] word_width;
    logic [15:0] line_px;
    logic [15:0] line_count;
    logic        last;
  } wrap_result_t;

  class wrap_scoreboard;
    logic [7:0]   glyph_w [256];
    logic [15:0]  wrap_w;
    int unsigned  line_acc, word_acc, line_no;
    bit           in_word, line_used;
    wrap_result_t placements[$];
    int           errors, checked, words, breaks;

    function new();
      foreach (glyph_w[i]) glyph_w[i] = 8'd0;
      wrap_w = WRAP_RESET;
      clear_text();
    endfunction

    function void clear_text();
      line_acc = 0;
      word_acc = 0;
      line_no = 0;
      in_word = 0;
      line_used = 0;
    endfunction

    function void set_wrap(logic [15:0] v);
      wrap_w = v;
    endfunction

    function int pending();
      return placements.size();
    endfunction

    function int unsigned clamp16(int unsigned v);
      return (v > MAX16) ? MAX16 : v;
    endfunction

    function void push_result(bit word, bit nl, int unsigned ww, bit fin);
      wrap_result_t r;
      int unsigned cnt;
      cnt = clamp16(line_no + 1);
      r.has_word = word;
      r.new_line = nl;
      r.line_idx = line_no[15:0];
      r.word_width = ww[15:0];
      r.line_px = line_acc[15:0];
      r.line_count = cnt[15:0];
      r.last = fin;
      placements.push_back(r);
    endfunction

    function void place_word(bit fin);
      int unsigned cand;
      bit nl;
      cand = line_acc + word_acc;
      if (line_used) cand += glyph_w[SPACE_CODE];
      nl = cand > wrap_w;
      if (nl) begin
        if (line_no < MAX16) line_no++;
        line_acc = word_acc;
      end else begin
        line_acc = clamp16(cand);
      end
      line_used = 1;
      push_result(1'b1, nl, word_acc, fin);
      word_acc = 0;
      in_word = 0;
    endfunction

    function void note_beat(logic cmd, logic [7:0] code, logic [7:0] gw, logic eot);
      if (cmd == CMD_WRITE) begin
        if (int'(code) < GWW_GLYPH_COUNT) glyph_w[code] = gw;
        return;
      end
      if (code == SPACE_CODE) begin
        if (in_word && !eot) begin
          place_word(1'b0);
          return;
        end
      end else if (code != NULL_CODE) begin
        word_acc = clamp16(word_acc + glyph_w[code]);
        in_word = 1;
      end
      if (!eot) return;
      if (in_word) place_word(1'b1);
      else push_result(1'b0, 1'b0, 0, 1'b1);
      clear_text();
    endfunction

    function void compare_field(string name, logic [15:0] e, logic [15:0] a);
      if (a !== e) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u,
                               logic l);
      wrap_result_t want;
      if (placements.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: unexpected result beat, expected none, got %0h/%0h/%0b",
                   $time, d, u, l);
        return;
      end
      want = placements.pop_front();
      checked++;
      if (want.has_word) words++;
      if (want.new_line) breaks++;
      compare_field("has_word", want.has_word, u[OUT_HAS_WORD_BIT]);
      compare_field("new_line", want.new_line, u[OUT_NEW_LINE_BIT]);
      compare_field("line_idx", want.line_idx, d[15:0]);
      compare_field("word_width", want.word_width, d[31:16]);
      compare_field("line_px", want.line_px, d[47:32]);
      compare_field("line_count", want.line_count, d[63:48]);
      compare_field("last", want.last, l);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // code[7:0], glyph_px[15:8]
  logic                   in_tuser = 1'b0; // cmd
  logic                   in_tlast = 1'b0; // end_of_text
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // line_idx, word_width, line_px, line_count
  logic [OUT_TUSER_W-1:0] out_tuser;       // has_word, new_line
  logic                   out_tlast;       // last
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [15:0]            cfg_data = '0;   // wrap_width

  wrap_scoreboard sb = new();
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int accepted_beats = 0;
  int wrap_settings = 1;
  int cycles = 0;

  greedy_word_wrap_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("[greedy_word_wrap_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_beat(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tlast);
        accepted_beats++;
      end
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  always @(negedge clk) out_tready <= (int'($urandom_range(99)) >= out_stall_pct);

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(logic cmd, logic [7:0] code, logic [7:0] gw, logic eot);
    while (int'($urandom_range(99)) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {gw, code};
    in_tlast <= eot;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_text(logic [7:0] code, logic eot);
    send_beat(CMD_TEXT, code, 8'($urandom_range(255)), eot);
  endtask

  task automatic load_glyph(logic [7:0] code, logic [7:0] w);
    send_beat(CMD_WRITE, code, w, 1'($urandom_range(1)));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_wrap(logic [15:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_wrap(v);
    wrap_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(99) < 85) return 8'h61 + 8'($urandom_range(7));
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_width();
    if ($urandom_range(4) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(15));
  endfunction

  task automatic random_glyph_load();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) load_glyph(8'h61 + 8'($urandom_range(7)), pick_width());
    else if (sel < 65) load_glyph(SPACE_CODE, 8'($urandom_range(12)));
    else load_glyph(8'($urandom_range(255)), pick_width());
  endtask

  task automatic send_noise();
    repeat ($urandom_range(3, 8)) begin
      send_beat(1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                $urandom_range(5) == 0);
    end
  endtask

  task automatic send_random_text();
    int nwords, len, ending;
    nwords = $urandom_range(1, 6);
    ending = $urandom_range(3);
    if ($urandom_range(3) == 0) send_text(SPACE_CODE, 1'b0);
    for (int w = 0; w < nwords; w++) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
      for (int c = 0; c < len; c++) begin
        if ($urandom_range(19) == 0) send_text(NULL_CODE, 1'b0);
        if ($urandom_range(14) == 0) random_glyph_load();
        send_text(pick_char(), (w == nwords - 1) && (c == len - 1) && (ending == 0));
      end
      if (w < nwords - 1) repeat ($urandom_range(1, 3)) send_text(SPACE_CODE, 1'b0);
    end
    case (ending)
      1: send_text(SPACE_CODE, 1'b1);
      2: send_text(NULL_CODE, 1'b1);
      3: begin
        repeat ($urandom_range(1, 2)) send_text(SPACE_CODE, 1'b0);
        send_text(SPACE_CODE, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic run_random(int beats);
    int start;
    start = accepted_beats;
    while (accepted_beats - start < beats) begin
      if ($urandom_range(9) == 0) send_noise();
      else send_random_text();
    end
  endtask

  int idle_by_phase [4] = '{0, 88, 0, 38};
  int stall_by_phase [4] = '{0, 0, 88, 38};

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: table extremes, spaces, empty bytes, every way a text can end
    load_glyph(8'h61, 8'd100);
    load_glyph(8'hFF, 8'd255);
    load_glyph(SPACE_CODE, 8'd10);
    load_glyph(NULL_CODE, 8'hFF);
    load_glyph(8'h62, 8'd0);
    send_text(SPACE_CODE, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(SPACE_CODE, 1'b0);
    send_text(SPACE_CODE, 1'b0);
    send_text(NULL_CODE, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h61, 1'b1);
    send_text(NULL_CODE, 1'b1);
    send_text(8'h61, 1'b0);
    send_text(SPACE_CODE, 1'b1);
    send_text(8'h61, 1'b0);
    send_text(SPACE_CODE, 1'b0);
    send_text(NULL_CODE, 1'b1);
    write_wrap(16'd0);
    send_text(8'h61, 1'b1);
    send_text(8'h62, 1'b0);
    send_text(8'h7F, 1'b1);

    // saturating word widths, then the exact candidate sum at the top wrap width
    write_wrap(16'hFFFF);
    repeat (258) send_text(8'hFF, 1'b0);
    send_text(SPACE_CODE, 1'b0);
    send_text(8'hFF, 1'b1);

    for (int p = 0; p < 4; p++) begin
      in_idle_pct = idle_by_phase[p];
      out_stall_pct = stall_by_phase[p];
      write_wrap(16'($urandom_range(16, 96)));
      for (int i = 0; i < 8; i++) load_glyph(8'h61 + 8'(i), pick_width());
      load_glyph(SPACE_CODE, 8'($urandom_range(8)));
      run_random(20);
      // sender holds off until the block has drained
      settle();
      case (p)
        0: write_wrap(16'hFFFF);
        1: write_wrap(16'd0);
        default: write_wrap(16'($urandom_range(65535)));
      endcase
      run_random(20);
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    settle();
    repeat (10) @(negedge clk);
    $display("%0d input beats under %0d wrap settings, %0d results checked",
             accepted_beats, wrap_settings, sb.checked);
    $display("%0d words placed, %0d line breaks, %0d mismatches",
             sb.words, sb.breaks, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[greedy_word_wrap_unit] OK");
    end else begin
      $display("[greedy_word_wrap_unit] ERROR");
    end
    $finish;
  end

endmodule
